// ===== src/signed_radix_digit_emitter_defines.svh =====
// assertion macros shared by the signed radix digit emitter
`ifndef SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SRE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SRE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sre_pkg.sv =====
// shared types, constants and helpers of the signed radix digit emitter
`default_nettype none

package sre_pkg;

	localparam int MAX_RADIX_DEF  = 16;
	localparam int VALUE_BITS_DEF = 32;

	// quotient bits resolved per cycle by the remainder unit
	localparam int DIV_STEP  = 8;
	localparam int SYM_COUNT = 16;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIX        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [4:0]  RADIX_RESET        = 5'd10;
	localparam logic [63:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
	localparam logic [63:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef logic [7:0] sym_t;
	typedef logic [4:0] radix_t;
	typedef logic [8*SYM_COUNT-1:0] symbols_t;

	typedef struct packed {
		logic done;
		logic ok;
	} chk_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_LD,
		ST_BAD
	} state_t;

	function automatic sym_t symbol_at(input symbols_t syms, input logic [3:0] idx);
		return syms[{idx, 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

// ===== src/sre_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module sre_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/sre_chk.sv =====
// alphabet checker: walks the symbols one per cycle, looking for signs and repeats, and checks the radix range
`default_nettype none

module sre_chk #(
	parameter int MAX_RADIX = sre_pkg::MAX_RADIX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sre_pkg::radix_t    radix,
	input  sre_pkg::symbols_t  symbols,
	output sre_pkg::chk_res_t  res
);

	import sre_pkg::*;

	logic       busy_q;
	logic [3:0] idx_q;
	sym_t       cur;
	logic       range_bad;
	logic       dup;
	logic       sym_bad;
	logic       fail;
	logic       last_idx;

	always_comb begin
		cur = symbol_at(symbols, idx_q);
		// compare the current symbol with every one before it
		dup = 1'b0;
		for (int j = 0; j < SYM_COUNT; j++) begin
			if ((4'(j) < idx_q) && (symbol_at(symbols, 4'(j)) == cur)) begin
				dup = 1'b1;
			end
		end
		range_bad = (radix < 5'd2) || (radix > 5'(MAX_RADIX));
		sym_bad   = (cur == CHAR_PLUS) || (cur == CHAR_MINUS) || dup;
		fail      = range_bad || sym_bad;
		last_idx  = ((5'(idx_q) + 5'd1) == radix);
		res.done  = busy_q && (fail || last_idx);
		res.ok    = !fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (res.done) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/sre_div.sv =====
// iterative divider by the radix: several restoring quotient bits per cycle
`default_nettype none

module sre_div #(
	parameter int VALUE_BITS = sre_pkg::VALUE_BITS_DEF,
	parameter int MAX_RADIX  = sre_pkg::MAX_RADIX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [VALUE_BITS-1:0]          dividend,
	input  logic [$clog2(MAX_RADIX+1)-1:0] divisor,
	output logic                           done,
	output logic [VALUE_BITS-1:0]          quotient,
	output logic [$clog2(MAX_RADIX+1)-1:0] remainder
);

	import sre_pkg::*;

	localparam int RW    = $clog2(MAX_RADIX + 1);
	localparam int STEPS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int DW    = STEPS * DIV_STEP;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DW-1:0]    dq_q;
	logic [RW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DW-1:0] dq_n;
	logic [RW-1:0] rem_n;
	logic [RW:0]   trial;

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_comb begin
		dq_n  = dq_q;
		rem_n = rem_q;
		trial = '0;
		for (int k = 0; k < DIV_STEP; k++) begin
			trial = {rem_n, dq_n[DW-1]};
			dq_n  = {dq_n[DW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial   = trial - {1'b0, divisor};
				dq_n[0] = 1'b1;
			end
			rem_n = trial[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= DW'(dividend);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q[VALUE_BITS-1:0];
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== src/signed_radix_digit_emitter.sv =====
// Signed integer to text in a programmable radix, one character per output word,
// most significant digit first, with a leading minus for negative values. Each value
// first has its radix and alphabet checked, one symbol per cycle, then is taken apart
// by one shared divider that resolves eight quotient bits per cycle; the digits go
// least significant first into a small ram and are read back in reverse, each digit
// through a ram read state and then an output load state, while the minus sign is
// loaded straight into the output register. Each load waits until the output register
// is free. A bad radix or alphabet yields a single word with tuser and tlast set. A new
// value is taken once the previous one has its last word in the output register.
`default_nettype none
`include "signed_radix_digit_emitter_defines.svh"

module signed_radix_digit_emitter #(
	parameter int MAX_RADIX  = sre_pkg::MAX_RADIX_DEF,
	parameter int VALUE_BITS = sre_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // value
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // character
	output logic                                 m_axis_tlast,
	output logic [0:0]                           m_axis_tuser,  // bad_base
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sre_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [63:0]                          cfg_data
);

	import sre_pkg::*;

	localparam int RW    = $clog2(MAX_RADIX + 1);
	localparam int DGW   = $clog2(MAX_RADIX);
	localparam int DEPTH = VALUE_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	state_t state_q, state_n;

	radix_t      radix_q;
	logic [63:0] sym_low_q;
	logic [63:0] sym_high_q;
	symbols_t    syms;

	logic                  neg_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [CW-1:0]         nd_q;
	logic [AW-1:0]         idx_q;

	logic out_valid_q;
	sym_t out_char_q;
	logic out_last_q;
	logic out_bad_q;

	logic [VALUE_BITS-1:0] value;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  slot_free;

	chk_res_t              chk_res;
	logic                  chk_start;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [RW-1:0]         div_rem;

	logic           ram_we;
	logic           ram_re;
	logic [DGW-1:0] ram_rdata;

	logic in_ready;
	logic out_load;
	sym_t out_char_n;
	logic out_last_n;
	logic out_bad_n;

	assign syms      = {sym_high_q, sym_low_q};
	assign value     = s_axis_tdata[VALUE_BITS-1:0];
	assign mag_in    = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
	assign slot_free = !out_valid_q || m_axis_tready;

	sre_chk #(
		.MAX_RADIX(MAX_RADIX)
	) u_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (chk_start),
		.radix  (radix_q),
		.symbols(syms),
		.res    (chk_res)
	);

	sre_div #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_RADIX (MAX_RADIX)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (radix_q[RW-1:0]),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// digits land least significant first and are read back from the top
	sre_ram #(
		.WIDTH(DGW),
		.DEPTH(DEPTH)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(nd_q[AW-1:0]),
		.wdata(div_rem[DGW-1:0]),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (chk_res.done) begin
					state_n = chk_res.ok ? ST_DIV : ST_BAD;
				end
			end
			ST_DIV: begin
				if (div_done && (div_quot == '0)) begin
					state_n = neg_q ? ST_SIGN : ST_RD;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					state_n = ST_RD;
				end
			end
			ST_RD: begin
				state_n = ST_LD;
			end
			ST_LD: begin
				if (slot_free) begin
					state_n = (idx_q == '0) ? ST_IDLE : ST_RD;
				end
			end
			ST_BAD: begin
				if (slot_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		chk_start    = 1'b0;
		div_start    = 1'b0;
		div_dividend = mag_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		out_load     = 1'b0;
		out_char_n   = '0;
		out_last_n   = 1'b0;
		out_bad_n    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				chk_start = s_axis_tvalid;
			end
			ST_CHECK: begin
				div_start = chk_res.done && chk_res.ok;
			end
			ST_DIV: begin
				// store this digit and restart on the quotient while it is nonzero
				ram_we       = div_done;
				div_start    = div_done && (div_quot != '0);
				div_dividend = div_quot;
			end
			ST_SIGN: begin
				out_load   = slot_free;
				out_char_n = CHAR_MINUS;
			end
			ST_RD: begin
				ram_re = 1'b1;
			end
			ST_LD: begin
				out_load   = slot_free;
				out_char_n = symbol_at(syms, 4'(ram_rdata));
				out_last_n = (idx_q == '0);
			end
			ST_BAD: begin
				out_load   = slot_free;
				out_last_n = 1'b1;
				out_bad_n  = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			nd_q        <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (chk_start) begin
				nd_q <= '0;
			end else if (ram_we) begin
				nd_q <= nd_q + 1'b1;
			end
			if (ram_we) begin
				idx_q <= nd_q[AW-1:0];
			end else if (out_load && (state_q == ST_LD) && (idx_q != '0)) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RESET;
			sym_low_q  <= SYMBOLS_LOW_RESET;
			sym_high_q <= SYMBOLS_HIGH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIX:        radix_q    <= cfg_data[4:0];
				REG_SYMBOLS_LOW:  sym_low_q  <= cfg_data;
				REG_SYMBOLS_HIGH: sym_high_q <= cfg_data;
				default: begin
					radix_q <= radix_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (chk_start) begin
			neg_q <= value[VALUE_BITS-1];
			mag_q <= mag_in;
		end
		if (out_load) begin
			out_char_q <= out_char_n;
			out_last_q <= out_last_n;
			out_bad_q  <= out_bad_n;
		end
	end

	assign s_axis_tready = in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;
	assign cfg_ready     = 1'b1;

	`SRE_ASSERT_IMP(a_bad_word_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "error word without tlast")
	`SRE_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV, "divider finished outside the digit phase")
	`SRE_ASSERT_IMP(a_digit_in_range, ram_we, nd_q < CW'(DEPTH), "digit count past the digit store")
	`SRE_ASSERT_NXT(a_fault_to_bad, (state_q == ST_CHECK) && chk_res.done && !chk_res.ok, state_q == ST_BAD, "alphabet fault did not lead to the error word")

endmodule

`default_nettype wire
